FILE: hw/rtl/rpn_pkg.sv
// ============================================================================
// rpn_pkg - shared definitions for the RPN stack evaluator
// Stack sizing, value format, token codes and the arithmetic unit status.
// ============================================================================
`default_nettype none

package rpn_pkg;

    // Stack sizing
    localparam int STACK_ENTRIES = 128;
    localparam int LEVEL_W       = $clog2(STACK_ENTRIES + 1);
    localparam int ADDR_W        = $clog2(STACK_ENTRIES);

    // Signed Q32.16 values
    localparam int VALUE_W = 48;
    localparam logic [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Token codes
    localparam int REQ_W = 3;
    localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SUB  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MUL  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DIV  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_END  = 3'd5;

    // Iteration counts of the shared add/subtract unit
    localparam int MUL_STEPS = VALUE_W;          // one multiplier bit per step
    localparam int DIV_STEPS = VALUE_W + 16;     // one quotient bit per step
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Status handed from the arithmetic unit to the sequencer
    typedef struct packed {
        logic done;   // result valid this cycle
        logic sat;    // result saturated
        logic dz;     // division by zero
    } t_arith_status;

endpackage

`default_nettype wire

FILE: hw/rtl/rpn_ram.sv
// ============================================================================
// rpn_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Read data holds when idle.
// ============================================================================
`default_nettype none

module rpn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rpn_arith.sv
// ============================================================================
// rpn_arith - iterative Q32.16 arithmetic unit
// Add/subtract with clamp, shift-add multiply and restoring divide, all on
// one shared 50-bit adder/subtractor driven by a small sequencer.
// ============================================================================
`default_nettype none

module rpn_arith import rpn_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [REQ_W-1:0]   i_op,
    input  wire logic [VALUE_W-1:0] i_a,
    input  wire logic [VALUE_W-1:0] i_b,
    output logic      [VALUE_W-1:0] o_result,
    output t_arith_status           o_status
);

    localparam int ADD_W = VALUE_W + 2;
    localparam int MAG_W = VALUE_W + 16;

    localparam logic [2:0] A_IDLE  = 3'd0;
    localparam logic [2:0] A_FIRST = 3'd1;
    localparam logic [2:0] A_ABSB  = 3'd2;
    localparam logic [2:0] A_LOOP  = 3'd3;
    localparam logic [2:0] A_FIX   = 3'd4;
    localparam logic [2:0] A_DONE  = 3'd5;

    logic [2:0]         r_state;
    logic [REQ_W-1:0]   r_op;
    logic               r_neg;
    logic               r_bneg;
    logic [VALUE_W-1:0] r_ma;
    logic [VALUE_W-1:0] r_mb;
    logic [VALUE_W-1:0] r_hi;     // product high half / remainder
    logic [MAG_W-1:0]   r_lo;     // multiplier bits / dividend and quotient
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_res;
    logic               r_sat;
    logic               r_dz;

    // shared adder
    logic [ADD_W-1:0] add_x;
    logic [ADD_W-1:0] add_y;
    logic             add_sub;
    logic [ADD_W-1:0] sum;

    logic               is_mul;
    logic               is_addsub;
    logic [VALUE_W:0]   hi_sum;
    logic [VALUE_W:0]   rem_sh;
    logic [VALUE_W-1:0] mb_abs;
    logic [MAG_W-1:0]   mag;
    logic               big;
    logic               over;
    logic               last_step;

    assign is_mul    = (r_op == REQ_MUL);
    assign is_addsub = (r_op == REQ_ADD) || (r_op == REQ_SUB);
    assign rem_sh    = {r_hi, r_lo[MAG_W-1]};

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (r_state)
            A_FIRST: begin
                if (is_addsub) begin
                    add_x   = {{2{r_mb[VALUE_W-1]}}, r_mb};
                    add_y   = {{2{r_ma[VALUE_W-1]}}, r_ma};
                    add_sub = (r_op == REQ_SUB);
                end else begin
                    add_y   = {{2{r_ma[VALUE_W-1]}}, r_ma};
                    add_sub = 1'b1;
                end
            end
            A_ABSB: begin
                add_y   = {{2{r_mb[VALUE_W-1]}}, r_mb};
                add_sub = 1'b1;
            end
            A_LOOP: begin
                if (is_mul) begin
                    add_x = {2'b00, r_hi};
                    add_y = {2'b00, r_mb};
                end else begin
                    add_x   = {1'b0, rem_sh};
                    add_y   = {2'b00, r_ma};
                    add_sub = 1'b1;
                end
            end
            A_FIX: begin
                add_y   = {2'b00, mag[VALUE_W-1:0]};
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
        sum = add_x + (add_y ^ {ADD_W{add_sub}}) + {{(ADD_W-1){1'b0}}, add_sub};
    end

    assign hi_sum    = r_lo[0] ? sum[VALUE_W:0] : {1'b0, r_hi};
    assign mb_abs    = r_mb[VALUE_W-1] ? sum[VALUE_W-1:0] : r_mb;
    assign last_step = is_mul ? (r_cnt == CNT_W'(MUL_STEPS - 1))
                              : (r_cnt == CNT_W'(DIV_STEPS - 1));

    // magnitude after the loop: product >> 16, or the quotient
    always_comb begin
        if (is_mul) begin
            mag = {r_hi[31:0], r_lo[VALUE_W-1:16]};
            big = |r_hi[VALUE_W-1:32];
        end else begin
            mag = r_lo;
            big = 1'b0;
        end
        over = big || (|mag[MAG_W-1:VALUE_W])
            || (mag[VALUE_W-1] && (!r_neg || (|mag[VALUE_W-2:0])));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_state <= A_FIRST;
                    end
                end
                A_FIRST: begin
                    if (is_addsub || (r_op == REQ_DIV && r_ma == '0)) begin
                        r_state <= A_DONE;
                    end else begin
                        r_state <= A_ABSB;
                    end
                end
                A_ABSB:  r_state <= A_LOOP;
                A_LOOP: begin
                    if (last_step) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX:   r_state <= A_DONE;
                A_DONE:  r_state <= A_IDLE;
                default: r_state <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    r_op   <= i_op;
                    r_ma   <= i_a;
                    r_mb   <= i_b;
                    r_neg  <= i_a[VALUE_W-1] ^ i_b[VALUE_W-1];
                    r_bneg <= i_b[VALUE_W-1];
                    r_sat  <= 1'b0;
                    r_dz   <= 1'b0;
                end
            end
            A_FIRST: begin
                if (is_addsub) begin
                    // exact 50-bit sum, clamp to 48 bits
                    if (sum[ADD_W-1:VALUE_W-1] != '0 && sum[ADD_W-1:VALUE_W-1] != '1) begin
                        r_sat <= 1'b1;
                        r_res <= sum[ADD_W-1] ? Q_MIN : Q_MAX;
                    end else begin
                        r_res <= sum[VALUE_W-1:0];
                    end
                end else if (r_op == REQ_DIV && r_ma == '0) begin
                    r_sat <= 1'b1;
                    r_dz  <= 1'b1;
                    r_res <= r_bneg ? Q_MIN : Q_MAX;
                end else if (r_ma[VALUE_W-1]) begin
                    r_ma <= sum[VALUE_W-1:0];
                end
            end
            A_ABSB: begin
                r_mb  <= mb_abs;
                r_hi  <= '0;
                r_cnt <= '0;
                r_lo  <= is_mul ? {16'b0, r_ma} : {mb_abs, 16'b0};
            end
            A_LOOP: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (is_mul) begin
                    r_hi <= hi_sum[VALUE_W:1];
                    r_lo <= {16'b0, hi_sum[0], r_lo[VALUE_W-1:1]};
                end else begin
                    // restoring step: keep the difference when non-negative
                    if (!sum[ADD_W-1]) begin
                        r_hi <= sum[VALUE_W-1:0];
                    end else begin
                        r_hi <= rem_sh[VALUE_W-1:0];
                    end
                    r_lo <= {r_lo[MAG_W-2:0], !sum[ADD_W-1]};
                end
            end
            A_FIX: begin
                if (over) begin
                    r_sat <= 1'b1;
                    r_res <= r_neg ? Q_MIN : Q_MAX;
                end else begin
                    r_res <= r_neg ? sum[VALUE_W-1:0] : mag[VALUE_W-1:0];
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_result      = r_res;
    assign o_status.done = (r_state == A_DONE);
    assign o_status.sat  = r_sat;
    assign o_status.dz   = r_dz;

endmodule

`default_nettype wire

FILE: hw/rtl/rpn_stack_evaluator_top.sv
// ============================================================================
// rpn_stack_evaluator_top - reverse-Polish evaluator over pre-split tokens
// Numbers are pushed; operators pop a then b and push b op a; an end token
// pops one value and returns it with the sticky saturation flags.
// ============================================================================
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  token   | in        | i_in_valid / o_in_stall   | i_req_type, i_operand_value
//  answer  | out       | o_out_valid / i_out_stall | o_answer, o_saturated,
//          |           |                           | o_divided_by_zero
//
//  Pushes and ignored codes leave the sequencer idle, so the token input
//  does not stall for them; operators pop, compute and push, with multiply
//  and divide looping one bit per step on the shared adder; an end token
//  also waits for the answer register to drain.
//  Reset is synchronous, active low; the stack contents need no clearing,
//  only the sequencer state, the level and the flags are reset.
//  A stalled answer does not block pushes or arithmetic; only the next end
//  token waits for it.
// ============================================================================
`default_nettype none

module rpn_stack_evaluator_top import rpn_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // token transactions
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [REQ_W-1:0]          i_req_type,
    input  wire logic signed [VALUE_W-1:0] i_operand_value,
    // answer transactions
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [VALUE_W-1:0]      o_answer,
    output logic                           o_saturated,
    output logic                           o_divided_by_zero
);

    // sequencer states
    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_POPA   = 3'd1;   // read top -> a
    localparam logic [2:0] T_POPB   = 3'd2;   // read next -> b
    localparam logic [2:0] T_CALC   = 3'd3;   // launch arithmetic
    localparam logic [2:0] T_WAIT   = 3'd4;   // wait, then push result
    localparam logic [2:0] T_ENDRD  = 3'd5;   // read top for the answer
    localparam logic [2:0] T_ENDOUT = 3'd6;   // load answer register

    logic [2:0]         r_state;
    logic [REQ_W-1:0]   r_op;
    logic [LEVEL_W-1:0] r_level;
    logic               r_sat_seen;
    logic               r_dz_seen;
    logic               r_a_vld;
    logic               r_b_vld;
    logic [VALUE_W-1:0] r_a;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_answer;
    logic               r_out_sat;
    logic               r_out_dz;

    logic               accept;
    logic               not_empty;
    logic               not_full;
    logic               out_free;
    logic [ADDR_W-1:0]  top_addr;

    // stack RAM ports
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [VALUE_W-1:0] ram_rdata;

    // arithmetic unit
    logic               alu_start;
    logic [VALUE_W-1:0] alu_b;
    logic [VALUE_W-1:0] alu_result;
    t_arith_status      alu_status;

    assign accept    = i_in_valid && !o_in_stall;
    assign not_empty = (r_level != '0);
    assign not_full  = (r_level < LEVEL_W'(STACK_ENTRIES));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign top_addr  = ADDR_W'(r_level - LEVEL_W'(1));

    assign o_in_stall = (r_state != T_IDLE);

    // ---- stack RAM access ----
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_level[ADDR_W-1:0];
        ram_wdata = i_operand_value;
        if (r_state == T_IDLE) begin
            ram_we = accept && (i_req_type == REQ_PUSH) && not_full;
        end else if (r_state == T_WAIT) begin
            ram_we    = alu_status.done && not_full;
            ram_wdata = alu_result;
        end
    end

    // pops read at level-1 in the pop states
    assign ram_re = ((r_state == T_POPA) || (r_state == T_POPB) || (r_state == T_ENDRD))
                    && not_empty;

    rpn_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_ENTRIES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (top_addr),
        .o_rdata (ram_rdata)
    );

    // ---- arithmetic ----
    assign alu_start = (r_state == T_CALC);
    assign alu_b     = r_b_vld ? ram_rdata : '0;   // empty pop reads as zero

    rpn_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (alu_start),
        .i_op     (r_op),
        .i_a      (r_a),
        .i_b      (alu_b),
        .o_result (alu_result),
        .o_status (alu_status)
    );

    // ---- sequencer and control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_level     <= '0;
            r_sat_seen  <= 1'b0;
            r_dz_seen   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // answer register loads from the end sequence, else drains
            if (r_state == T_ENDOUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        case (i_req_type)
                            REQ_PUSH: begin
                                if (not_full) begin
                                    r_level <= r_level + LEVEL_W'(1);
                                end
                            end
                            REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
                                r_state <= T_POPA;
                            end
                            REQ_END: begin
                                r_state <= T_ENDRD;
                            end
                            default: begin
                                r_state <= T_IDLE;   // unused codes ignored
                            end
                        endcase
                    end
                end
                T_POPA, T_POPB, T_ENDRD: begin
                    if (not_empty) begin
                        r_level <= r_level - LEVEL_W'(1);
                    end
                    case (r_state)
                        T_POPA:  r_state <= T_POPB;
                        T_POPB:  r_state <= T_CALC;
                        default: r_state <= T_ENDOUT;
                    endcase
                end
                T_CALC: begin
                    r_state <= T_WAIT;
                end
                T_WAIT: begin
                    if (alu_status.done) begin
                        if (not_full) begin
                            r_level <= r_level + LEVEL_W'(1);
                        end
                        r_sat_seen <= r_sat_seen || alu_status.sat;
                        r_dz_seen  <= r_dz_seen || alu_status.dz;
                        r_state    <= T_IDLE;
                    end
                end
                T_ENDOUT: begin
                    if (out_free) begin
                        r_sat_seen  <= 1'b0;
                        r_dz_seen   <= 1'b0;
                        r_state     <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        if (r_state == T_IDLE && accept) begin
            r_op <= i_req_type;
        end
        if (r_state == T_POPA || r_state == T_ENDRD) begin
            r_a_vld <= not_empty;
        end
        if (r_state == T_POPB) begin
            r_a     <= r_a_vld ? ram_rdata : '0;
            r_b_vld <= not_empty;
        end
        if (r_state == T_ENDOUT && out_free) begin
            r_answer  <= r_a_vld ? ram_rdata : '0;
            r_out_sat <= r_sat_seen;
            r_out_dz  <= r_dz_seen;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_answer          = r_answer;
    assign o_saturated       = r_out_sat;
    assign o_divided_by_zero = r_out_dz;

endmodule

`default_nettype wire

FILE: hw/rtl/rpn_checker.sv
// ============================================================================
// rpn_checker - port-level checks for the RPN stack evaluator
// Watches the top-level ports only; attached by bind.
// ============================================================================
`default_nettype none

module rpn_checker import rpn_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_stall,
    input wire logic [REQ_W-1:0]          i_req_type,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic signed [VALUE_W-1:0] o_answer,
    input wire logic                      o_saturated,
    input wire logic                      o_divided_by_zero
);

    // a stalled answer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_answer))
        else $error("answer changed while stalled");

    // operator and end transactions occupy the sequencer
    a_busy_after_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_req_type == REQ_ADD || i_req_type == REQ_SUB
            || i_req_type == REQ_MUL || i_req_type == REQ_DIV || i_req_type == REQ_END)
        |=> o_in_stall)
        else $error("no stall after operator or end transaction");

    // a push leaves the token input unstalled
    a_push_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_req_type == REQ_PUSH |=> !o_in_stall)
        else $error("stall after push transaction");

    // division by zero always saturates too
    a_dz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divided_by_zero |-> o_saturated)
        else $error("zero-divide flag without saturation flag");

endmodule

bind rpn_stack_evaluator_top rpn_checker u_rpn_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_req_type        (i_req_type),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_answer          (o_answer),
    .o_saturated       (o_saturated),
    .o_divided_by_zero (o_divided_by_zero)
);

`default_nettype wire
